/* rtl/bce_pkg.sv */
// Shared types and constants for the bitmap circle erase engine.
// Request/response words, request codes and memory sizing.
// No dependencies.
package bce_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int PIX_W      = 32;
	localparam int DIM_W      = 9;
	localparam int COORD_W    = 16;
	localparam int WIDE_W     = 18;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'd1;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_ERASE = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_NONE  = 2'd3
	} req_code_t;

	typedef struct packed {
		req_code_t                  req_type;
		logic signed [COORD_W-1:0]  pos_x;
		logic signed [COORD_W-1:0]  pos_y;
		logic [7:0]                 radius;
		logic [7:0]                 red;
		logic [7:0]                 green;
		logic [7:0]                 blue;
		logic [7:0]                 alpha;
	} req_t;

	typedef struct packed {
		logic solid;
		logic changed;
	} rsp_t;

endpackage

/* rtl/bitmap_circle_erase_engine.sv */
// Top level of the bitmap circle erase engine: request sequencer around the pixel RAM.
// Depends on bce_pkg and bce_ram.
//
// Usage:
//   cfg_we/cfg_index/cfg_data write map_width (index 0) or map_height (index 1),
//   taken at any edge with cfg_we high; write them only while the block is idle.
//   req_valid/req_ready take one request word; rsp_valid/rsp_ready return one
//   response word per request, in order.
//   States from request accept to response load:
//     write or unused code: EXEC, DONE; query: EXEC, READ, DONE, READ being
//     skipped out of bounds; erase: EXEC, SETUP, SWEEP over each pixel of the
//     clipped bounding box, DONE (EXEC, DONE when the box is empty). The erase
//     sweep is set by the single RAM write port, one pixel per cycle.
//   One request is in flight at a time; req_ready returns the cycle after the
//   response is loaded. A stalled receiver holds one finished response while
//   the next request proceeds; a second finished response waits until the
//   first is taken.
//   After reset the RAM is cleared one word per cycle, all MAX_WIDTH*MAX_HEIGHT
//   words (65536 by default); req_ready stays low during the clear while
//   configuration writes are still taken.
module bitmap_circle_erase_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bce_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bce_pkg::DIM_W-1:0]          cfg_data,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  bce_pkg::req_t                      req,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output bce_pkg::rsp_t                      rsp
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_EXEC  = 7'b0000100,
		ST_SETUP = 7'b0001000,
		ST_SWEEP = 7'b0010000,
		ST_READ  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t                           state_q;
	logic [bce_pkg::DIM_W-1:0]        map_width_q;
	logic [bce_pkg::DIM_W-1:0]        map_height_q;
	logic [bce_pkg::DIM_W-1:0]        eff_w;
	logic [bce_pkg::DIM_W-1:0]        eff_h;
	bce_pkg::req_t                    req_q;
	logic [bce_pkg::ADDR_W-1:0]       clr_q;
	logic [bce_pkg::DIM_W-1:0]        x_q;
	logic [bce_pkg::DIM_W-1:0]        y_q;
	logic [bce_pkg::DIM_W-1:0]        x0_q;
	logic [bce_pkg::DIM_W-1:0]        x1_q;
	logic [bce_pkg::DIM_W-1:0]        y1_q;
	logic [bce_pkg::WIDE_W-1:0]       base_q;
	logic [15:0]                      r2_q;
	logic                             solid_q;
	logic                             changed_q;
	logic                             rsp_valid_q;
	bce_pkg::rsp_t                    rsp_q;

	logic                             in_bounds;
	logic [bce_pkg::WIDE_W-1:0]       pt_addr;
	logic signed [bce_pkg::WIDE_W-1:0] sx;
	logic signed [bce_pkg::WIDE_W-1:0] sy;
	logic signed [bce_pkg::WIDE_W-1:0] srad;
	logic signed [bce_pkg::WIDE_W-1:0] bx0;
	logic signed [bce_pkg::WIDE_W-1:0] bx1;
	logic signed [bce_pkg::WIDE_W-1:0] by0;
	logic signed [bce_pkg::WIDE_W-1:0] by1;
	logic signed [bce_pkg::WIDE_W-1:0] lim_w;
	logic signed [bce_pkg::WIDE_W-1:0] lim_h;
	logic                             box_empty;
	logic signed [bce_pkg::WIDE_W-1:0] dx_w;
	logic signed [bce_pkg::WIDE_W-1:0] dy_w;
	logic signed [8:0]                dx;
	logic signed [8:0]                dy;
	logic [17:0]                      dx2;
	logic [17:0]                      dy2;
	logic [17:0]                      d2;
	logic                             in_circle;
	logic [bce_pkg::WIDE_W-1:0]       sweep_addr;
	logic                             load_rsp;

	logic                             mem_we;
	logic [bce_pkg::ADDR_W-1:0]       mem_addr;
	logic [bce_pkg::PIX_W-1:0]        mem_wdata;
	logic [bce_pkg::PIX_W-1:0]        mem_rdata;

	assign eff_w = (32'(map_width_q) > bce_pkg::MAX_WIDTH) ?
		bce_pkg::DIM_W'(bce_pkg::MAX_WIDTH) : map_width_q;
	assign eff_h = (32'(map_height_q) > bce_pkg::MAX_HEIGHT) ?
		bce_pkg::DIM_W'(bce_pkg::MAX_HEIGHT) : map_height_q;

	// point access
	assign in_bounds = !req_q.pos_x[15] && !req_q.pos_y[15]
		&& (15'(req_q.pos_x) < 15'(eff_w)) && (15'(req_q.pos_y) < 15'(eff_h));
	assign pt_addr = bce_pkg::WIDE_W'(req_q.pos_y[8:0]) * bce_pkg::WIDE_W'(eff_w)
		+ bce_pkg::WIDE_W'(req_q.pos_x[8:0]);

	// erase bounding box, clipped to the map
	assign sx    = bce_pkg::WIDE_W'(req_q.pos_x);
	assign sy    = bce_pkg::WIDE_W'(req_q.pos_y);
	assign srad  = signed'(bce_pkg::WIDE_W'(req_q.radius));
	assign lim_w = signed'(bce_pkg::WIDE_W'(eff_w)) - 18'sd1;
	assign lim_h = signed'(bce_pkg::WIDE_W'(eff_h)) - 18'sd1;

	always_comb begin
		bx0 = sx - srad;
		bx1 = sx + srad;
		by0 = sy - srad;
		by1 = sy + srad;
		if (bx0 < 0) begin
			bx0 = '0;
		end
		if (by0 < 0) begin
			by0 = '0;
		end
		if (bx1 > lim_w) begin
			bx1 = lim_w;
		end
		if (by1 > lim_h) begin
			by1 = lim_h;
		end
	end

	assign box_empty = (bx0 > bx1) || (by0 > by1);

	// distance test for the current pixel
	assign dx_w = signed'(bce_pkg::WIDE_W'(x_q)) - sx;
	assign dy_w = signed'(bce_pkg::WIDE_W'(y_q)) - sy;
	assign dx   = dx_w[8:0];
	assign dy   = dy_w[8:0];
	assign dx2  = unsigned'(bce_pkg::WIDE_W'(dx) * bce_pkg::WIDE_W'(dx));
	assign dy2  = unsigned'(bce_pkg::WIDE_W'(dy) * bce_pkg::WIDE_W'(dy));
	assign d2   = dx2 + dy2;
	assign in_circle = d2 <= 18'(r2_q);
	assign sweep_addr = base_q + bce_pkg::WIDE_W'(x_q);

	assign load_rsp  = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = bce_pkg::ADDR_W'(pt_addr);
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			ST_EXEC: begin
				mem_we    = (req_q.req_type == bce_pkg::REQ_WRITE) && in_bounds;
				mem_wdata = {req_q.alpha, req_q.blue, req_q.green, req_q.red};
			end
			ST_SWEEP: begin
				mem_we   = in_circle;
				mem_addr = bce_pkg::ADDR_W'(sweep_addr);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	bce_ram #(
		.WIDTH(bce_pkg::PIX_W),
		.DEPTH(bce_pkg::MAP_DEPTH)
	) u_pixels (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= bce_pkg::DIM_W'(256);
			map_height_q <= bce_pkg::DIM_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				bce_pkg::CFG_MAP_WIDTH:  map_width_q  <= cfg_data;
				bce_pkg::CFG_MAP_HEIGHT: map_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == bce_pkg::ADDR_W'(bce_pkg::MAP_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (req_q.req_type == bce_pkg::REQ_QUERY && in_bounds) begin
						state_q <= ST_READ;
					end else if (req_q.req_type == bce_pkg::REQ_ERASE && !box_empty) begin
						state_q <= ST_SETUP;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SETUP: begin
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (x_q == x1_q && y_q == y1_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (load_rsp) begin
			rsp_q.solid   <= solid_q;
			rsp_q.changed <= changed_q;
		end
		unique case (state_q)
			ST_EXEC: begin
				solid_q   <= 1'b0;
				changed_q <= 1'b0;
				x0_q      <= bx0[bce_pkg::DIM_W-1:0];
				x1_q      <= bx1[bce_pkg::DIM_W-1:0];
				x_q       <= bx0[bce_pkg::DIM_W-1:0];
				y_q       <= by0[bce_pkg::DIM_W-1:0];
				y1_q      <= by1[bce_pkg::DIM_W-1:0];
				r2_q      <= 16'(req_q.radius) * 16'(req_q.radius);
			end
			ST_SETUP: begin
				base_q <= bce_pkg::WIDE_W'(y_q) * bce_pkg::WIDE_W'(eff_w);
			end
			ST_SWEEP: begin
				if (in_circle) begin
					changed_q <= 1'b1;
				end
				if (x_q == x1_q) begin
					x_q    <= x0_q;
					y_q    <= y_q + 1'b1;
					base_q <= base_q + bce_pkg::WIDE_W'(eff_w);
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			ST_READ: begin
				solid_q <= (mem_rdata[31:24] != 8'd0);
			end
			default: ;
		endcase
	end

endmodule

/* rtl/bce_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// One access per cycle; read data valid the cycle after the address.
// No dependencies.
module bce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                            wdata,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
